/* design/sntp_response_decoder_core_defines.svh */
// assertion helpers, expect clk and arst_n in the enclosing module
`ifndef SNTP_RESPONSE_DECODER_CORE_DEFINES_SVH
`define SNTP_RESPONSE_DECODER_CORE_DEFINES_SVH

// same-cycle implication
`define SRD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SRD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/srd_pkg.sv */
`default_nettype none

package srd_pkg;

	localparam int PACKET_BYTES = 48;
	localparam int REFID_OFFSET = 12;
	localparam int REFID_BYTES  = 4;

	localparam int IDX_W      = 6;
	localparam int WORD_BYTES = 4;

	localparam int RECV_SEC_POS  = 32;
	localparam int RECV_FRAC_POS = 36;
	localparam int XMIT_SEC_POS  = 40;
	localparam int XMIT_FRAC_POS = 44;

	localparam int TS_N    = 2;
	localparam int TS_RECV = 0;
	localparam int TS_XMIT = 1;

	localparam logic [31:0] NTP_UNIX_OFFSET = 32'd2208988800;
	localparam logic [29:0] NS_PER_S        = 30'd1000000000;
	localparam logic [31:0] FRAC_FULL       = 32'hFFFF_FFFF;

	// fraction * 1e9 and seconds * 1e9 both stay below 2^62
	localparam int PROD_W = 62;
	localparam int Q_W    = PROD_W - 32;
	// half of the divisor, rounded down, for round half up
	localparam logic [PROD_W-1:0] RND_BIAS = PROD_W'(64'h7FFF_FFFF);

	localparam int TOL_W = 40;
	localparam logic [TOL_W-1:0] TOL_RESET = 40'd1000000000;

	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 64;
	localparam int REG_IDX_W = PADDR_W - 3;
	localparam logic [REG_IDX_W-1:0] REG_TOLERANCE = '0;

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic [7:0]  stratum;
		logic [31:0] ref_id;
		logic [63:0] client_send;
		logic [63:0] client_recv;
		logic [63:0] now;
	} srd_side_t;

	typedef struct packed {
		srd_side_t              side;
		logic [TS_N-1:0][31:0] unix_sec;
		logic [TS_N-1:0][31:0] frac;
	} srd_rec_t;

endpackage

`default_nettype wire

/* design/srd_front.sv */
`default_nettype none
`include "sntp_response_decoder_core_defines.svh"

module srd_front import srd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  packet_byte,
	input  wire logic [63:0] client_send_ns,
	input  wire logic [63:0] client_recv_ns,
	input  wire logic [63:0] now_ns,
	output logic             push,
	output srd_rec_t         push_rec,
	input  wire logic        fifo_full
);

	logic [IDX_W-1:0] idx_q;
	logic [7:0]       stratum_q, stratum_n;
	logic [31:0]      refid_q, refid_n;
	logic [31:0]      rsec_q, rsec_n, rfrac_q, rfrac_n;
	logic [31:0]      xsec_q, xsec_n, xfrac_q, xfrac_n;
	logic             acc;
	logic             last;

	function automatic logic in_word(input logic [IDX_W-1:0] i, input int pos, input int len);
		return (i >= IDX_W'(pos)) && (i < IDX_W'(pos + len));
	endfunction

	function automatic logic [31:0] shift_word(input logic [31:0] w, input logic first,
			input logic [7:0] b);
		return first ? {24'd0, b} : {w[23:0], b};
	endfunction

	assign last     = (idx_q == IDX_W'(PACKET_BYTES - 1));
	// only the final word needs room downstream
	assign in_ready = !last || !fifo_full;
	assign acc      = in_valid && in_ready;
	assign push     = acc && last;

	always_comb begin
		stratum_n = stratum_q;
		refid_n   = refid_q;
		rsec_n    = rsec_q;
		rfrac_n   = rfrac_q;
		xsec_n    = xsec_q;
		xfrac_n   = xfrac_q;
		if (idx_q == IDX_W'(1)) begin
			stratum_n = packet_byte;
		end
		if (in_word(idx_q, REFID_OFFSET, REFID_BYTES)) begin
			refid_n = shift_word(refid_q, idx_q == IDX_W'(REFID_OFFSET), packet_byte);
		end
		if (in_word(idx_q, RECV_SEC_POS, WORD_BYTES)) begin
			rsec_n = shift_word(rsec_q, idx_q == IDX_W'(RECV_SEC_POS), packet_byte);
		end
		if (in_word(idx_q, RECV_FRAC_POS, WORD_BYTES)) begin
			rfrac_n = shift_word(rfrac_q, idx_q == IDX_W'(RECV_FRAC_POS), packet_byte);
		end
		if (in_word(idx_q, XMIT_SEC_POS, WORD_BYTES)) begin
			xsec_n = shift_word(xsec_q, idx_q == IDX_W'(XMIT_SEC_POS), packet_byte);
		end
		if (in_word(idx_q, XMIT_FRAC_POS, WORD_BYTES)) begin
			xfrac_n = shift_word(xfrac_q, idx_q == IDX_W'(XMIT_FRAC_POS), packet_byte);
		end
	end

	always_comb begin
		push_rec.side.stratum     = stratum_n;
		push_rec.side.ref_id      = refid_n;
		push_rec.side.client_send = client_send_ns;
		push_rec.side.client_recv = client_recv_ns;
		push_rec.side.now         = now_ns;
		// ntp era to unix epoch, wraps mod 2^32
		push_rec.unix_sec[TS_RECV] = rsec_n - NTP_UNIX_OFFSET;
		push_rec.unix_sec[TS_XMIT] = xsec_n - NTP_UNIX_OFFSET;
		push_rec.frac[TS_RECV]     = rfrac_n;
		push_rec.frac[TS_XMIT]     = xfrac_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			stratum_q <= '0;
			refid_q   <= '0;
			rsec_q    <= '0;
			rfrac_q   <= '0;
			xsec_q    <= '0;
			xfrac_q   <= '0;
		end else if (acc) begin
			idx_q     <= last ? '0 : idx_q + IDX_W'(1);
			stratum_q <= stratum_n;
			refid_q   <= refid_n;
			rsec_q    <= rsec_n;
			rfrac_q   <= rfrac_n;
			xsec_q    <= xsec_n;
			xfrac_q   <= xfrac_n;
		end
	end

	`SRD_ASSERT_NXT(a_idx_wrap, acc && last, idx_q == '0, "byte index did not wrap")

endmodule

`default_nettype wire

/* design/srd_fifo.sv */
`default_nettype none
`include "sntp_response_decoder_core_defines.svh"

module srd_fifo import srd_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire srd_rec_t push_rec,
	output logic          full,
	input  wire logic     pop,
	output srd_rec_t      pop_rec,
	output logic          empty
);

	srd_rec_t           mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CW-1:0] count_q;

	function automatic logic [FIFO_AW-1:0] ptr_inc(input logic [FIFO_AW-1:0] p);
		return (p == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_AW'(1);
	endfunction

	assign full    = (count_q == FIFO_CW'(FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign pop_rec = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + FIFO_CW'(1);
				2'b01:   count_q <= count_q - FIFO_CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`SRD_ASSERT_IMP(a_no_overflow, push, count_q < FIFO_CW'(FIFO_DEPTH) || pop, "push while full")
	`SRD_ASSERT_IMP(a_no_underflow, pop, count_q != '0, "pop while empty")

endmodule

`default_nettype wire

/* design/srd_back.sv */
`default_nettype none
`include "sntp_response_decoder_core_defines.svh"

module srd_back import srd_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [TOL_W-1:0] tolerance,
	input  wire srd_rec_t         rec,
	input  wire logic             empty,
	output logic                  pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [7:0]            stratum,
	output logic [31:0]           ref_id,
	output logic [63:0]           server_recv_ns,
	output logic [63:0]           server_xmit_ns,
	output logic                  sane
);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	srd_side_t side_s1, side_s2, side_s3, side_s4, side_s5;

	logic [TS_N-1:0][PROD_W-1:0] frac_s1, sec_s1;
	logic [TS_N-1:0][PROD_W-1:0] rnd_s2, sec_s2;
	logic [TS_N-1:0][Q_W-1:0]    q_s3;
	logic [TS_N-1:0][PROD_W-1:0] sec_s3;
	logic [TS_N-1:0][PROD_W-1:0] ts_s4, ts_s5, ts_s6;

	logic        le_bc_s5, le_ad_s5, le_an_s5;
	logic [63:0] da_s5, na_s5, x_s5, y_s5;

	logic [7:0]  stratum_s6;
	logic [31:0] ref_id_s6;
	logic        sane_s6;

	logic [TS_N-1:0][32:0] fold;
	logic [63:0]           a, b, c, d, n;
	logic [64:0]           xy_sum;

	// whole pipe moves together, held only by a stalled output word
	assign en  = !v_s6 || out_ready;
	assign pop = en && !empty;

	// fraction / (2^32 - 1): hi*(2^32-1) + hi + lo, one correction step
	always_comb begin
		for (int i = 0; i < TS_N; i++) begin
			fold[i] = 33'(rnd_s2[i][PROD_W-1:32]) + 33'(rnd_s2[i][31:0]);
		end
	end

	assign a = side_s4.client_send;
	assign d = side_s4.client_recv;
	assign n = side_s4.now;
	assign b = 64'(ts_s4[TS_RECV]);
	assign c = 64'(ts_s4[TS_XMIT]);

	assign xy_sum = 65'(x_s5) + 65'(y_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= !empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= rec.side;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
			side_s5 <= side_s4;
			for (int i = 0; i < TS_N; i++) begin
				frac_s1[i] <= PROD_W'(rec.frac[i]) * PROD_W'(NS_PER_S);
				sec_s1[i]  <= PROD_W'(rec.unix_sec[i]) * PROD_W'(NS_PER_S);
				rnd_s2[i]  <= frac_s1[i] + RND_BIAS;
				sec_s2[i]  <= sec_s1[i];
				q_s3[i]    <= rnd_s2[i][PROD_W-1:32] + Q_W'(fold[i] >= {1'b0, FRAC_FULL});
				sec_s3[i]  <= sec_s2[i];
				ts_s4[i]   <= sec_s3[i] + PROD_W'(q_s3[i]);
				ts_s5[i]   <= ts_s4[i];
				ts_s6[i]   <= ts_s5[i];
			end
			le_bc_s5 <= b <= c;
			le_ad_s5 <= a <= d;
			le_an_s5 <= a <= n;
			da_s5    <= d - a;
			na_s5    <= n - a;
			x_s5     <= (d > c) ? d - c : c - d;
			y_s5     <= (b > a) ? b - a : a - b;
			stratum_s6 <= side_s5.stratum;
			ref_id_s6  <= side_s5.ref_id;
			sane_s6    <= le_bc_s5 && le_ad_s5 && le_an_s5
				&& (da_s5 <= 64'(tolerance))
				&& (na_s5 <= 64'(tolerance))
				&& (xy_sum <= 65'(tolerance));
		end
	end

	assign out_valid      = v_s6;
	assign stratum        = stratum_s6;
	assign ref_id         = ref_id_s6;
	assign server_recv_ns = 64'(ts_s6[TS_RECV]);
	assign server_xmit_ns = 64'(ts_s6[TS_XMIT]);
	assign sane           = sane_s6;

	`SRD_ASSERT_IMP(a_sane_order, out_valid && sane, server_recv_ns <= server_xmit_ns, "recv after xmit")
	`SRD_ASSERT_NXT(a_pop_enters, pop, v_s1, "popped word lost before first stage")

endmodule

`default_nettype wire

/* design/sntp_response_decoder_core.sv */
// path: the word carrying the final packet byte pushes its record into the queue, then through the result pipe
// throughput: one packet byte per cycle unless the final byte waits for room; one result per packet of 48 bytes
// the result pipe holds on a stalled output word; a 2-entry queue then absorbs packets,
// after which only the final byte of a packet waits for room
// reset: byte counter, queue and pipe valids clear; tolerance_ns returns to 1000000000
`default_nettype none

module sntp_response_decoder_core import srd_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         packet_byte,
	input  wire logic [63:0]        client_send_ns,
	input  wire logic [63:0]        client_recv_ns,
	input  wire logic [63:0]        now_ns,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [7:0]              stratum,
	output logic [31:0]             ref_id,
	output logic [63:0]             server_recv_ns,
	output logic [63:0]             server_xmit_ns,
	output logic                    sane,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0]      prdata,
	output logic                    pready
);

	logic [TOL_W-1:0]     tol_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;

	logic     push, pop, full, empty;
	srd_rec_t push_rec, pop_rec;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:3];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (wr_en && reg_idx == REG_TOLERANCE) begin
			tol_q <= pwdata[TOL_W-1:0];
		end
	end

	always_comb begin
		case (reg_idx)
			REG_TOLERANCE: prdata = PDATA_W'(tol_q);
			default:       prdata = '0;
		endcase
	end

	srd_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.packet_byte    (packet_byte),
		.client_send_ns (client_send_ns),
		.client_recv_ns (client_recv_ns),
		.now_ns         (now_ns),
		.push           (push),
		.push_rec       (push_rec),
		.fifo_full      (full)
	);

	srd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.full     (full),
		.pop      (pop),
		.pop_rec  (pop_rec),
		.empty    (empty)
	);

	srd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.tolerance      (tol_q),
		.rec            (pop_rec),
		.empty          (empty),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.stratum        (stratum),
		.ref_id         (ref_id),
		.server_recv_ns (server_recv_ns),
		.server_xmit_ns (server_xmit_ns),
		.sane           (sane)
	);

endmodule

`default_nettype wire
